// ===== rtl/core/ryuv_pkg.sv =====
package ryuv_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE         = 2'd2;

  // Register field widths and reset values
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned SCALE_W = 4;
  localparam logic [DIM_W-1:0]   WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]   HEIGHT_RST = 13'd480;
  localparam logic [SCALE_W-1:0] SCALE_RST  = 4'd1;

  // BT.601 integer coefficients
  localparam logic signed [17:0] C_YR  = 18'sd66;
  localparam logic signed [17:0] C_YG  = 18'sd129;
  localparam logic signed [17:0] C_YB  = 18'sd25;
  localparam logic signed [17:0] C_UR  = -18'sd38;
  localparam logic signed [17:0] C_UG  = -18'sd74;
  localparam logic signed [17:0] C_UB  = 18'sd112;
  localparam logic signed [17:0] C_VR  = 18'sd112;
  localparam logic signed [17:0] C_VG  = -18'sd94;
  localparam logic signed [17:0] C_VB  = -18'sd18;
  localparam logic signed [17:0] ROUND = 18'sd128;
  localparam logic signed [17:0] OFF_Y = 18'sd16;
  localparam logic signed [17:0] OFF_C = 18'sd128;

  // One converted pixel
  typedef struct packed {
    logic [7:0] y;
    logic [7:0] cb;
    logic [7:0] cr;
  } ryuv_pix_t;

  // floor((sum + 128) / 256) + offset, clamped to 0..255
  function automatic logic [7:0] conv(input logic signed [17:0] sum,
                                      input logic signed [17:0] off);
    logic signed [17:0] v;
    begin
      v = ((sum + ROUND) >>> 8) + off;
      if (v < 18'sd0) begin
        conv = 8'd0;
      end else if (v > 18'sd255) begin
        conv = 8'd255;
      end else begin
        conv = v[7:0];
      end
    end
  endfunction

endpackage

// ===== rtl/core/ryuv_csc.sv =====
// Color space conversion of one pixel, RGB to BT.601 YCbCr
module ryuv_csc (
  input  logic [7:0]           blue,
  input  logic [7:0]           green,
  input  logic [7:0]           red,
  output ryuv_pkg::ryuv_pix_t  pix
);
  import ryuv_pkg::*;

  logic signed [17:0] b_s, g_s, r_s;
  logic signed [17:0] sum_y, sum_u, sum_v;

  assign b_s = signed'({10'd0, blue});
  assign g_s = signed'({10'd0, green});
  assign r_s = signed'({10'd0, red});

  // Constant-coefficient sums of products
  assign sum_y = C_YR * r_s + C_YG * g_s + C_YB * b_s;
  assign sum_u = C_UR * r_s + C_UG * g_s + C_UB * b_s;
  assign sum_v = C_VR * r_s + C_VG * g_s + C_VB * b_s;

  assign pix.y  = conv(sum_y, OFF_Y);
  assign pix.cb = conv(sum_u, OFF_C);
  assign pix.cr = conv(sum_v, OFF_C);

endmodule

// ===== rtl/core/rgb_to_yuv420_semiplanar_upscale.sv =====
// RGB to YCbCr 4:2:0 converter with integer upscaling. Each accepted source
// pixel yields scale output pixels (luma replicated horizontally); last marks
// the final one. The source must present each row scale times for vertical
// replication. On even output rows every second output pixel carries a chroma
// pair (Cb in chroma_first, Cr in chroma_second); otherwise both read zero.
// Timing: a request is registered in the input register, then occupies the
// output register while it is replicated scale times, so throughput is one
// source pixel per cycle at scale 1 while out_stall is low. The next request
// is taken while the current one is being replicated. Zero-valued registers
// act as 1, oversized ones saturate at MAX_WIDTH / MAX_SCALE. Write registers
// only while the block is idle.
module rgb_to_yuv420_semiplanar_upscale #(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned MAX_SCALE = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  logic [ryuv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ryuv_pkg::DIM_W-1:0]   cfg_data,
  // source pixel requests
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_blue,
  input  logic [7:0]                   in_green,
  input  logic [7:0]                   in_red,
  // output pixel requests
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_luma,
  output logic                         out_chroma_valid,
  output logic [7:0]                   out_chroma_first,
  output logic [7:0]                   out_chroma_second,
  output logic                         out_last
);
  import ryuv_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SW = $clog2(MAX_SCALE + 1);
  localparam int unsigned RW = $clog2(MAX_WIDTH * MAX_SCALE + 1);

  // Configuration registers
  logic [DIM_W-1:0]   src_width_r, src_height_r;
  logic [SCALE_W-1:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= WIDTH_RST;
      src_height_r <= HEIGHT_RST;
      scale_r      <= SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH:  src_width_r  <= cfg_data;
        REG_SOURCE_HEIGHT: src_height_r <= cfg_data;
        REG_SCALE:         scale_r      <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective limits: zero acts as one, oversize saturates
  logic [CW-1:0] w_eff, h_eff;
  logic [SW-1:0] s_eff;
  logic [RW-1:0] rows;

  assign w_eff = (src_width_r == '0) ? CW'(1) :
                 (32'(src_width_r) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(src_width_r);
  assign h_eff = (src_height_r == '0) ? CW'(1) :
                 (32'(src_height_r) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(src_height_r);
  assign s_eff = (scale_r == '0) ? SW'(1) :
                 (32'(scale_r) > MAX_SCALE) ? SW'(MAX_SCALE) : SW'(scale_r);
  assign rows  = RW'(RW'(h_eff) * RW'(s_eff));

  // Input register
  logic       a_valid_r;
  logic [7:0] a_blue_r, a_green_r, a_red_r;
  logic       a_adv;

  // Output register
  logic          o_valid_r;
  ryuv_pix_t     o_pix_r;
  logic          o_even_r;
  logic          o_par_r;
  logic [SW-1:0] o_cnt_r, o_cnt_nxt;
  logic [SW-1:0] o_scale_r;
  logic          o_last;
  logic          o_take;
  logic          o_done;
  logic          o_cv;

  assign o_take = o_valid_r && !out_stall;
  assign o_last = (o_cnt_r == o_scale_r - SW'(1));
  assign o_done = o_take && o_last;
  assign a_adv  = a_valid_r && (!o_valid_r || o_done);
  assign in_stall = a_valid_r && !a_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (!in_stall) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_blue_r  <= in_blue;
      a_green_r <= in_green;
      a_red_r   <= in_red;
    end
  end

  // Pixel conversion
  ryuv_pix_t a_pix;

  ryuv_csc u_csc (
    .blue  (a_blue_r),
    .green (a_green_r),
    .red   (a_red_r),
    .pix   (a_pix)
  );

  // Frame position counters
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          par_r, par_nxt;
  logic [CW-1:0] col1, col2;
  logic [RW-1:0] row1, row2, row3;
  logic          par1, par2;
  logic          even_row;

  always_comb begin
    // wrap left over from a register change
    col1 = col_r;
    row1 = row_r;
    par1 = par_r;
    if (col_r >= w_eff) begin
      col1 = '0;
      row1 = row_r + RW'(1);
    end
    row2 = row1;
    if (row1 >= rows) begin
      row2 = '0;
      par1 = 1'b0;
    end
    even_row = !row2[0];
    // advance by one source pixel, scale output pixels
    col2 = col1 + CW'(1);
    par2 = par1 ^ s_eff[0];
    row3 = row2;
    col_nxt = col2;
    par_nxt = par2;
    if (col2 >= w_eff) begin
      col_nxt = '0;
      row3 = row2 + RW'(1);
      if (row3 >= rows) begin
        row3 = '0;
        par_nxt = 1'b0;
      end
    end
    row_nxt = row3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      par_r <= 1'b0;
    end else if (a_adv) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      par_r <= par_nxt;
    end
  end

  // Replication counter and output valid
  always_comb begin
    o_cnt_nxt = o_cnt_r;
    if (a_adv) begin
      o_cnt_nxt = '0;
    end else if (o_take) begin
      o_cnt_nxt = o_cnt_r + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
      o_cnt_r   <= '0;
    end else begin
      o_cnt_r <= o_cnt_nxt;
      if (a_adv) begin
        o_valid_r <= 1'b1;
      end else if (o_done) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      o_pix_r   <= a_pix;
      o_even_r  <= even_row;
      o_par_r   <= par1;
      o_scale_r <= s_eff;
    end
  end

  // Chroma rides on even rows at even global pixel count
  assign o_cv = o_even_r && !(o_par_r ^ o_cnt_r[0]);

  assign out_valid         = o_valid_r;
  assign out_luma          = o_pix_r.y;
  assign out_chroma_valid  = o_cv;
  assign out_chroma_first  = o_cv ? o_pix_r.cb : 8'd0;
  assign out_chroma_second = o_cv ? o_pix_r.cr : 8'd0;
  assign out_last          = o_last;

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ryuv_pkg::*;

  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned MAX_REP = 8;
  localparam int unsigned CYCLE_LIMIT = 600000;

  // one output pixel as seen on the result channel
  typedef struct {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] cb;
    logic [7:0] cr;
    logic       last;
  } out_pix_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SOURCE_WIDTH;
  logic [DIM_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_blue = 8'd0;
  logic [7:0]         in_green = 8'd0;
  logic [7:0]         in_red = 8'd0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_luma;
  logic               out_chroma_valid;
  logic [7:0]         out_chroma_first;
  logic [7:0]         out_chroma_second;
  logic               out_last;

  rgb_to_yuv420_semiplanar_upscale uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_blue           (in_blue),
    .in_green          (in_green),
    .in_red            (in_red),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_luma          (out_luma),
    .out_chroma_valid  (out_chroma_valid),
    .out_chroma_first  (out_chroma_first),
    .out_chroma_second (out_chroma_second),
    .out_last          (out_last)
  );

  // predictor copy of registers and counters
  logic [DIM_W-1:0]   width_reg;
  logic [DIM_W-1:0]   height_reg;
  logic [SCALE_W-1:0] scale_reg;
  int unsigned        src_col;
  int unsigned        dst_row;
  bit                 dst_parity;

  out_pix_t expected_pixels[$];

  int unsigned n_errors = 0;
  int unsigned n_requests = 0;
  int unsigned n_results = 0;
  int unsigned n_chroma = 0;
  int unsigned n_settings = 0;
  int unsigned cycle_count = 0;

  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;
  int unsigned stall_hold = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // mostly short idle stretches, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      pick_gap = 0;
    end else if (roll < 90) begin
      pick_gap = $urandom_range(1, 3);
    end else begin
      pick_gap = $urandom_range(8, 30);
    end
  endfunction

  // zero acts as 1, oversized saturates
  function automatic int unsigned effective(input int unsigned v, input int unsigned hi);
    if (v == 0) begin
      effective = 1;
    end else if (v > hi) begin
      effective = hi;
    end else begin
      effective = v;
    end
  endfunction

  // floor((sum + 128) / 256) + offset, clamped to a byte
  function automatic logic [7:0] to_byte(input int sum, input int offset);
    int v;
    v = ((sum + 128) >>> 8) + offset;
    if (v < 0) begin
      to_byte = 8'd0;
    end else if (v > 255) begin
      to_byte = 8'd255;
    end else begin
      to_byte = v[7:0];
    end
  endfunction

  // converts one source pixel and queues its replicated output pixels
  task automatic convert_and_replicate(input logic [7:0] b8, input logic [7:0] g8,
                                       input logic [7:0] r8);
    int          b;
    int          g;
    int          r;
    int unsigned w_eff;
    int unsigned rows;
    int unsigned s_eff;
    int unsigned k;
    logic [7:0]  y;
    logic [7:0]  cb;
    logic [7:0]  cr;
    bit          even_row;
    out_pix_t    px;
    b = int'(b8);
    g = int'(g8);
    r = int'(r8);
    w_eff = effective(32'(width_reg), MAX_DIM);
    s_eff = effective(32'(scale_reg), MAX_REP);
    rows = effective(32'(height_reg), MAX_DIM) * s_eff;
    y = to_byte(66 * r + 129 * g + 25 * b, 16);
    cb = to_byte(-38 * r - 74 * g + 112 * b, 128);
    cr = to_byte(112 * r - 94 * g - 18 * b, 128);
    // counters beyond a shrunk limit wrap first
    if (src_col >= w_eff) begin
      src_col = 0;
      dst_row++;
    end
    if (dst_row >= rows) begin
      dst_row = 0;
      dst_parity = 1'b0;
    end
    even_row = (dst_row % 2) == 0;
    for (k = 0; k < s_eff; k++) begin
      px.luma = y;
      px.chroma_valid = even_row && !dst_parity;
      px.cb = px.chroma_valid ? cb : 8'd0;
      px.cr = px.chroma_valid ? cr : 8'd0;
      px.last = (k + 1 == s_eff);
      expected_pixels.push_back(px);
      dst_parity = !dst_parity;
    end
    src_col++;
    if (src_col >= w_eff) begin
      src_col = 0;
      dst_row++;
      if (dst_row >= rows) begin
        dst_row = 0;
        dst_parity = 1'b0;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      n_errors++;
    end
  endtask

  // predictor update and result check, both on the sampled edge
  always @(posedge clk) begin
    out_pix_t want;
    if (!rst_n) begin
      width_reg = WIDTH_RST;
      height_reg = HEIGHT_RST;
      scale_reg = SCALE_RST;
      src_col = 0;
      dst_row = 0;
      dst_parity = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SOURCE_WIDTH: width_reg = cfg_data;
          REG_SOURCE_HEIGHT: height_reg = cfg_data;
          REG_SCALE: scale_reg = cfg_data[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        convert_and_replicate(in_blue, in_green, in_red);
        n_requests++;
      end
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected output pixel: expected none, actual luma %0d",
                   $time, out_luma);
          n_errors++;
        end else begin
          want = expected_pixels.pop_front();
          if (want.chroma_valid) begin
            n_chroma++;
          end
          check_field("luma", want.luma, out_luma);
          check_field("chroma_valid", {7'd0, want.chroma_valid}, {7'd0, out_chroma_valid});
          check_field("chroma_first", want.cb, out_chroma_first);
          check_field("chroma_second", want.cr, out_chroma_second);
          check_field("last", {7'd0, want.last}, {7'd0, out_last});
        end
      end
    end
  end

  // random receiver stalls
  always @(posedge clk) begin
    if (!stalls_on) begin
      out_stall <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_hold <= pick_gap();
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("rgb_to_yuv420_semiplanar_upscale test failed");
      $finish;
    end
  end

  // one source pixel request; valid stays up for back-to-back requests
  task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
    int unsigned gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_blue <= b;
    in_green <= g;
    in_red <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop sending and let every outstanding output pixel arrive
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input logic [DIM_W-1:0] s);
    wait_idle();
    write_reg(REG_SOURCE_WIDTH, w);
    write_reg(REG_SOURCE_HEIGHT, h);
    write_reg(REG_SCALE, s);
    n_settings++;
  endtask

  // bias channels toward the byte extremes
  function automatic logic [7:0] pick_channel();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      pick_channel = 8'd0;
    end else if (roll == 1) begin
      pick_channel = 8'd255;
    end else begin
      pick_channel = 8'($urandom_range(0, 255));
    end
  endfunction

  // primaries, secondaries, black and white at the reset geometry
  task automatic test_reset_defaults();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    wait_idle();
  endtask

  // zero registers act as 1, oversized ones saturate
  task automatic test_degenerate_registers();
    configure(13'd0, 13'd0, 13'd0);
    send_pixel(8'd12, 8'd200, 8'd99);
    send_pixel(8'd255, 8'd0, 8'd128);
    stalls_on = 1'b1;
    configure(13'h1FFF, 13'h1FFF, 13'd15);
    send_pixel(8'd1, 8'd2, 8'd3);
    send_pixel(8'd254, 8'd127, 8'd64);
    send_pixel(8'd0, 8'd255, 8'd0);
    wait_idle();
    stalls_on = 1'b0;
  endtask

  // shrink width then height while counters sit past the new limits
  task automatic test_midframe_change();
    configure(13'd4, 13'd3, 13'd1);
    send_pixel(8'd10, 8'd20, 8'd30);
    send_pixel(8'd40, 8'd50, 8'd60);
    send_pixel(8'd70, 8'd80, 8'd90);
    wait_idle();
    write_reg(REG_SOURCE_WIDTH, 13'd2);
    send_pixel(8'd100, 8'd110, 8'd120);
    wait_idle();
    write_reg(REG_SOURCE_HEIGHT, 13'd1);
    send_pixel(8'd130, 8'd140, 8'd150);
    send_pixel(8'd160, 8'd170, 8'd180);
    wait_idle();
  endtask

  // random pixels under one geometry; pauses halfway until fully drained
  task automatic run_random_phase(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                  input logic [DIM_W-1:0] s, input int unsigned count,
                                  input bit gaps, input bit stalls);
    int unsigned i;
    configure(w, h, s);
    gaps_on = gaps;
    stalls_on = stalls;
    for (i = 0; i < count; i++) begin
      if (i == count / 2) begin
        wait_idle();
      end
      send_pixel(pick_channel(), pick_channel(), pick_channel());
    end
    wait_idle();
  endtask

  task automatic test_random_traffic();
    run_random_phase(13'd3, 13'd2, 13'd2, 40, 1'b1, 1'b1);
    run_random_phase(13'd5, 13'd3, 13'd1, 40, 1'b1, 1'b0);
    run_random_phase(13'd1, 13'd1, 13'd8, 30, 1'b0, 1'b1);
    // upper data bits beyond the scale field are dropped
    run_random_phase(13'd2, 13'd4, 13'h1FF3, 40, 1'b1, 1'b1);
    run_random_phase(13'd7, 13'd2, 13'd4, 40, 1'b1, 1'b1);
    run_random_phase(13'd4096, 13'd1, 13'd1, 30, 1'b0, 1'b0);
    run_random_phase(13'd1, 13'd4096, 13'd1, 30, 1'b1, 1'b1);
    run_random_phase(13'd6, 13'd5, 13'd5, 30, 1'b1, 1'b1);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_degenerate_registers();
    test_midframe_change();
    test_random_traffic();

    // final drain
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    wait_idle();
    repeat (10) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      $display("%0t: %0d output pixels never arrived", $time, expected_pixels.size());
      n_errors++;
    end

    $display("Sent %0d source pixels under %0d geometries plus reset defaults;",
             n_requests, n_settings);
    $display("checked %0d output pixels, %0d of them carrying chroma, %0d errors.",
             n_results, n_chroma, n_errors);
    if (n_errors == 0) begin
      $display("rgb_to_yuv420_semiplanar_upscale test passed");
    end else begin
      $display("rgb_to_yuv420_semiplanar_upscale test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ryuv_pkg.sv
rtl/core/ryuv_csc.sv
rtl/core/rgb_to_yuv420_semiplanar_upscale.sv
dv/tb_top.sv
